FILE: rtl/grouped_priority_request_scheduler_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grouped priority request scheduler
// Clocked on clk_i; the first form is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef GROUPED_PRIORITY_REQUEST_SCHEDULER_CORE_ASSERT_SVH
`define GROUPED_PRIORITY_REQUEST_SCHEDULER_CORE_ASSERT_SVH

// Property checked outside reset
`define GPRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included
`define GPRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/gprs_pkg.sv
// ---------------------------------------------------------------------------
// gprs_pkg
// Shared types, codes and defaults of the grouped priority request scheduler.
// ---------------------------------------------------------------------------
package gprs_pkg;

  // Default sizes
  localparam int GPRS_GROUP_SLOTS        = 16;
  localparam int GPRS_REQUESTS_PER_GROUP = 32;
  localparam int GPRS_REQUEST_ID_SPACE   = 256;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_INSERT     = 3'd0,
    KIND_MOVE_TOP   = 3'd1,
    KIND_SET_ENABLE = 3'd2,
    KIND_ITER_START = 3'd3,
    KIND_ITER_NEXT  = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TABLE_FULL = 2'd1,
    STATUS_LIST_FULL  = 2'd2,
    STATUS_NOT_FOUND  = 2'd3
  } status_e;

  // Input item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] request_id;
    logic [7:0] group_key;
    logic       enable_value;
  } item_t;

  // Result item
  typedef struct packed {
    logic              walk_valid;
    logic signed [8:0] current_request;
    logic signed [8:0] current_group;
    logic [1:0]        status;
  } res_t;

endpackage

FILE: rtl/grouped_priority_request_scheduler_core.sv
// ---------------------------------------------------------------------------
// grouped_priority_request_scheduler_core
// Ordered table of priority groups with request lists and a deduplicating
// walk over the enabled groups.
//
//   Channel  Dir  tdata                                  tuser
//   s_axis   in   request_id, group_key, enable_value    kind
//   m_axis   out  current_request, current_group         walk_valid, status
//
// Insert, move and set-enable search the group keys in rank order, one rank per cycle.
// A walk step makes a registered read of the request store and then of the seen
// map for each stored request visited, and steps past disabled or exhausted groups.
// Reset is asynchronous and clears control state; a clearing pass then zeroes
// the seen map with the input held off, and the same pass runs again at every
// 255th walk start.
// A new item is taken while the previous result waits in the output register.
// ---------------------------------------------------------------------------
module grouped_priority_request_scheduler_core
  import gprs_pkg::*;
#(
  parameter int GROUP_SLOTS        = GPRS_GROUP_SLOTS,
  parameter int REQUESTS_PER_GROUP = GPRS_REQUESTS_PER_GROUP,
  parameter int REQUEST_ID_SPACE   = GPRS_REQUEST_ID_SPACE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // request_id[7:0], group_key[15:8], enable_value[16]
  input  logic [2:0]  s_axis_tuser_i,  // kind[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // current_request[8:0], current_group[17:9]
  output logic [2:0]  m_axis_tuser_o   // walk_valid[0], status[2:1]
);

  localparam int AW = $clog2(GROUP_SLOTS * REQUESTS_PER_GROUP);

  item_t         item;
  res_t          res;
  res_t          out_q;
  logic          out_valid_q;
  logic          res_valid;
  logic          res_ready;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Unpack the input beat
  always_comb begin
    item.kind         = s_axis_tuser_i;
    item.request_id   = s_axis_tdata_i[7:0];
    item.group_key    = s_axis_tdata_i[15:8];
    item.enable_value = s_axis_tdata_i[16];
  end

  gprs_ctrl #(
    .GROUP_SLOTS       (GROUP_SLOTS),
    .REQUESTS_PER_GROUP(REQUESTS_PER_GROUP),
    .REQUEST_ID_SPACE  (REQUEST_ID_SPACE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s_axis_tvalid_i),
    .item_ready_o(s_axis_tready_o),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  gprs_ram #(
    .WIDTH(8),
    .DEPTH(GROUP_SLOTS * REQUESTS_PER_GROUP)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // Pack the output beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.current_group, out_q.current_request};
  assign m_axis_tuser_o  = {out_q.status, out_q.walk_valid};

endmodule

FILE: rtl/gprs_ram.sv
// ---------------------------------------------------------------------------
// gprs_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module gprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gprs_ctrl.sv
// ---------------------------------------------------------------------------
// gprs_ctrl
// Group table, seen map and sequencer: key search, table updates and the
// walk over the request store.
// ---------------------------------------------------------------------------
`include "grouped_priority_request_scheduler_core_assert.svh"

module gprs_ctrl
  import gprs_pkg::*;
#(
  parameter int GROUP_SLOTS        = GPRS_GROUP_SLOTS,
  parameter int REQUESTS_PER_GROUP = GPRS_REQUESTS_PER_GROUP,
  parameter int REQUEST_ID_SPACE   = GPRS_REQUEST_ID_SPACE,
  localparam int AW = $clog2(GROUP_SLOTS * REQUESTS_PER_GROUP)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  output logic          item_ready_o,
  input  item_t         item_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output res_t          res_o,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output logic [7:0]    ram_wdata_o,
  output logic          ram_re_o,
  output logic [AW-1:0] ram_raddr_o,
  input  logic [7:0]    ram_rdata_i
);

  localparam int SW  = $clog2(GROUP_SLOTS);
  localparam int GTW = $clog2(GROUP_SLOTS + 1);
  localparam int PW  = (REQUESTS_PER_GROUP > 1) ? $clog2(REQUESTS_PER_GROUP) : 1;
  localparam int TW  = $clog2(REQUESTS_PER_GROUP + 1);
  localparam int IW  = $clog2(REQUEST_ID_SPACE);
  localparam int EW  = 8;
  localparam logic [GTW-1:0] GS_T  = GTW'(GROUP_SLOTS);
  localparam logic [TW-1:0]  RPG_T = TW'(REQUESTS_PER_GROUP);
  localparam logic [EW-1:0]  EPOCH_LAST = '1;
  localparam logic [IW-1:0]  CLR_LAST   = IW'(REQUEST_ID_SPACE - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_SEEK,
    ST_CHECK,
    ST_MARK,
    ST_DONE
  } state_e;

  state_e           state_q;
  item_t            item_q;
  logic [SW-1:0]    rank_q [GROUP_SLOTS];
  logic [7:0]       key_q [GROUP_SLOTS];
  logic             en_q [GROUP_SLOTS];
  logic [TW-1:0]    total_q [GROUP_SLOTS];
  logic [GTW-1:0]   group_total_q;
  logic [EW-1:0]    epoch_q;
  logic [IW-1:0]    clr_ptr_q;
  logic             clr_start_q;
  logic [GTW-1:0]   rank_ptr_q;
  logic [TW-1:0]    pos_ptr_q;
  logic [SW-1:0]    walk_rank_q;
  logic [PW-1:0]    walk_pos_q;
  logic             walk_live_q;
  logic [7:0]       cur_req_q;
  logic [7:0]       cur_grp_q;
  status_e          status_q;

  logic [SW-1:0]    cur_slot;
  logic             scan_in;
  logic             key_hit;
  logic             resolve;
  logic [TW-1:0]    tot_s;
  logic             list_full;
  logic             table_full;
  logic             seek_ok;
  logic             id_in_range;
  logic             seen_hit;

  logic             seen_we;
  logic [IW-1:0]    seen_waddr;
  logic [EW-1:0]    seen_wdata;
  logic             seen_re;
  logic [IW-1:0]    seen_raddr;
  logic [EW-1:0]    seen_rdata;

  // Slot at the scan rank and its lookups
  always_comb begin
    cur_slot    = rank_q[rank_ptr_q[SW-1:0]];
    scan_in     = rank_ptr_q < group_total_q;
    key_hit     = scan_in && (key_q[cur_slot] == item_q.group_key);
    resolve     = !scan_in || key_hit;
    tot_s       = total_q[cur_slot];
    list_full   = tot_s >= RPG_T;
    table_full  = group_total_q >= GS_T;
    seek_ok     = scan_in && en_q[cur_slot] && (pos_ptr_q < tot_s);
    id_in_range = 32'(ram_rdata_i) < REQUEST_ID_SPACE;
    seen_hit    = id_in_range && (seen_rdata == epoch_q);
  end

  // Request store ports: append in the search step, read in the seek step
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(AW'(cur_slot) * AW'(REQUESTS_PER_GROUP) + AW'(tot_s));
    ram_wdata_o = item_q.request_id;
    if (state_q == ST_FIND && resolve && item_q.kind == KIND_INSERT) begin
      if (key_hit) begin
        ram_we_o = !list_full;
      end else begin
        ram_we_o    = !table_full;
        ram_waddr_o = AW'(AW'(group_total_q[SW-1:0]) * AW'(REQUESTS_PER_GROUP));
      end
    end
    ram_re_o    = (state_q == ST_SEEK) && seek_ok;
    ram_raddr_o = AW'(AW'(cur_slot) * AW'(REQUESTS_PER_GROUP) + AW'(pos_ptr_q[PW-1:0]));
  end

  // Seen map ports: read the epoch of the fetched id, stamp it when given,
  // zero every entry during a clearing pass
  always_comb begin
    seen_re    = (state_q == ST_CHECK);
    seen_raddr = IW'(ram_rdata_i);
    seen_we    = 1'b0;
    seen_waddr = IW'(ram_rdata_i);
    seen_wdata = epoch_q;
    if (state_q == ST_CLEAR) begin
      seen_we    = 1'b1;
      seen_waddr = clr_ptr_q;
      seen_wdata = '0;
    end else if (state_q == ST_MARK && !seen_hit && id_in_range) begin
      seen_we = 1'b1;
    end
  end

  gprs_ram #(
    .WIDTH(EW),
    .DEPTH(REQUEST_ID_SPACE)
  ) u_seen (
    .clk_i  (clk_i),
    .we_i   (seen_we),
    .waddr_i(seen_waddr),
    .wdata_i(seen_wdata),
    .re_i   (seen_re),
    .raddr_i(seen_raddr),
    .rdata_o(seen_rdata)
  );

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      group_total_q <= '0;
      epoch_q       <= EW'(1);
      clr_ptr_q     <= '0;
      clr_start_q   <= 1'b0;
      rank_ptr_q    <= '0;
      pos_ptr_q     <= '0;
      walk_rank_q   <= '0;
      walk_pos_q    <= '0;
      walk_live_q   <= 1'b0;
      status_q      <= STATUS_OK;
      for (int i = 0; i < GROUP_SLOTS; i++) begin
        en_q[i]    <= 1'b0;
        total_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_ptr_q <= clr_ptr_q + IW'(1);
          if (clr_ptr_q == CLR_LAST) begin
            epoch_q     <= EW'(1);
            clr_start_q <= 1'b0;
            state_q     <= clr_start_q ? ST_SEEK : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid_i) begin
            status_q   <= STATUS_OK;
            rank_ptr_q <= '0;
            pos_ptr_q  <= '0;
            case (item_i.kind)
              KIND_INSERT, KIND_MOVE_TOP, KIND_SET_ENABLE: begin
                state_q <= ST_FIND;
              end
              KIND_ITER_START: begin
                // Advance the epoch; wipe the map once the epochs run out
                if (epoch_q == EPOCH_LAST) begin
                  clr_ptr_q   <= '0;
                  clr_start_q <= 1'b1;
                  state_q     <= ST_CLEAR;
                end else begin
                  epoch_q <= epoch_q + EW'(1);
                  state_q <= ST_SEEK;
                end
              end
              KIND_ITER_NEXT: begin
                if (walk_live_q) begin
                  rank_ptr_q <= GTW'(walk_rank_q);
                  pos_ptr_q  <= TW'(walk_pos_q) + TW'(1);
                  state_q    <= ST_SEEK;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_FIND: begin
          if (!resolve) begin
            rank_ptr_q <= rank_ptr_q + GTW'(1);
          end else begin
            state_q <= ST_DONE;
            case (item_q.kind)
              KIND_INSERT: begin
                if (key_hit) begin
                  if (list_full) begin
                    status_q <= STATUS_LIST_FULL;
                  end else begin
                    total_q[cur_slot] <= tot_s + TW'(1);
                    en_q[cur_slot]    <= item_q.enable_value;
                    walk_live_q       <= 1'b0;
                  end
                end else if (table_full) begin
                  status_q <= STATUS_TABLE_FULL;
                end else begin
                  en_q[group_total_q[SW-1:0]]    <= item_q.enable_value;
                  total_q[group_total_q[SW-1:0]] <= TW'(1);
                  group_total_q                  <= group_total_q + GTW'(1);
                  walk_live_q                    <= 1'b0;
                end
              end
              KIND_MOVE_TOP: begin
                if (key_hit) begin
                  en_q[cur_slot] <= 1'b1;
                  walk_live_q    <= 1'b0;
                end else begin
                  status_q <= STATUS_NOT_FOUND;
                end
              end
              KIND_SET_ENABLE: begin
                if (key_hit) begin
                  en_q[cur_slot] <= item_q.enable_value;
                  walk_live_q    <= 1'b0;
                end else begin
                  status_q <= STATUS_NOT_FOUND;
                end
              end
              default: begin
                status_q <= STATUS_OK;
              end
            endcase
          end
        end
        ST_SEEK: begin
          if (!scan_in) begin
            walk_live_q <= 1'b0;
            state_q     <= ST_DONE;
          end else if (seek_ok) begin
            state_q <= ST_CHECK;
          end else begin
            rank_ptr_q <= rank_ptr_q + GTW'(1);
            pos_ptr_q  <= '0;
          end
        end
        ST_CHECK: begin
          state_q <= ST_MARK;
        end
        ST_MARK: begin
          if (!seen_hit) begin
            walk_rank_q <= rank_ptr_q[SW-1:0];
            walk_pos_q  <= pos_ptr_q[PW-1:0];
            walk_live_q <= 1'b1;
            state_q     <= ST_DONE;
          end else begin
            pos_ptr_q <= pos_ptr_q + TW'(1);
            state_q   <= ST_SEEK;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Table payload: rank order, keys, latched item and current request and group
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i) begin
      item_q <= item_i;
    end
    if (state_q == ST_FIND && resolve && item_q.kind == KIND_INSERT && !key_hit
        && !table_full) begin
      rank_q[group_total_q[SW-1:0]] <= group_total_q[SW-1:0];
      key_q[group_total_q[SW-1:0]]  <= item_q.group_key;
    end
    // Rotate the found group to the front
    if (state_q == ST_FIND && key_hit && item_q.kind == KIND_MOVE_TOP) begin
      for (int i = 1; i < GROUP_SLOTS; i++) begin
        if (GTW'(i) <= rank_ptr_q) begin
          rank_q[i] <= rank_q[i-1];
        end
      end
      rank_q[0] <= cur_slot;
    end
    if (state_q == ST_MARK && !seen_hit) begin
      cur_req_q <= ram_rdata_i;
      cur_grp_q <= key_q[cur_slot];
    end
  end

  // Result of the finished item
  assign item_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = (state_q == ST_DONE);
  always_comb begin
    res_o.walk_valid      = walk_live_q;
    res_o.current_request = walk_live_q ? $signed({1'b0, cur_req_q}) : '1;
    res_o.current_group   = walk_live_q ? $signed({1'b0, cur_grp_q}) : '1;
    res_o.status          = status_q;
  end

  `GPRS_ASSERT(a_total_bound, group_total_q <= GS_T, "group count above table size")
  `GPRS_ASSERT(a_check_after_seek, state_q == ST_CHECK |-> $past(state_q) == ST_SEEK,
               "store data checked without a read")
  `GPRS_ASSERT(a_walk_in_table, walk_live_q |-> GTW'(walk_rank_q) < group_total_q,
               "live walk points past the table")
  `GPRS_ASSERT(a_result_held, res_valid_o && !res_ready_i |=> res_valid_o,
               "result dropped before taken")
  `GPRS_ASSERT_ALWAYS(a_idle_no_write, state_q == ST_IDLE |-> !ram_we_o,
                      "store written while idle")

endmodule
